FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the median filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/imf_pkg.sv
// ---------------------------------------------------------------------------
// Median filter package
// Sizes, codes, shared types and the window edge fold function.
// ---------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

  localparam int WIN_ROWS     = 3;
  localparam int WIN_COLS     = 3;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 3;

  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = NUM_CH * CH_W;
  localparam int WIN_N   = WIN_ROWS * WIN_COLS;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int CHN_W    = 2;
  localparam int CFG_DW   = 12;
  localparam int CFG_IDX_W = 2;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WEFF_W   = COL_W + 1;
  localparam int ROW_W    = HEIGHT_W;
  localparam int RING_B   = $clog2(2 * WIN_ROWS);
  localparam int RING_ROWS = 1 << RING_B;
  localparam int POS_W    = ((ROW_W > COL_W + 1) ? ROW_W : COL_W + 1) + 2;
  localparam int DIFF_W   = $clog2((WIN_ROWS - 1) * MAX_WIDTH + WIN_COLS + 1);

  localparam int PIPE_LAT   = WIN_N + 3;
  localparam int FIFO_AW    = $clog2(PIPE_LAT + 2);
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int PEND_W     = FIFO_AW + 1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic [CHN_W-1:0] nch;
    logic             eof;
  } side_t;

  typedef struct packed {
    side_t                                side;
    logic [WIN_ROWS-1:0][RING_B-1:0]      slot;
    logic [WIN_COLS-1:0][COL_W-1:0]       col;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [RING_B-1:0] slot;
    logic [COL_W-1:0]  col;
  } wr_req_t;

  typedef struct packed {
    logic [PEND_W-1:0] pend;
    logic [PEND_W-1:0] count;
  } mrg_status_t;

  function automatic logic signed [POS_W-1:0] fold_pos(
    input logic signed [POS_W-1:0] p,
    input logic signed [POS_W-1:0] size,
    input logic signed [POS_W-1:0] lim
  );
    logic signed [POS_W-1:0] q;
    q = p;
    if (q < 0) begin
      q = q + size;
    end else if (q >= lim) begin
      q = q - size;
    end
    if (q < 0) begin
      q = '0;
    end
    if (q >= lim) begin
      q = lim - POS_W'(1);
    end
    return q;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/imf_if.sv
// ---------------------------------------------------------------------------
// Median filter channels
// Valid/ready interfaces for the pixel input and the result output.
// ---------------------------------------------------------------------------
`default_nettype none

interface imf_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [imf_pkg::CH_W-1:0] chan0;
  logic [imf_pkg::CH_W-1:0] chan1;
  logic [imf_pkg::CH_W-1:0] chan2;

  modport source (output valid, output op, output chan0, output chan1, output chan2,
                  input ready);
  modport sink (input valid, input op, input chan0, input chan1, input chan2,
                output ready);
endinterface

interface imf_res_if;
  logic                     valid;
  logic                     ready;
  logic [imf_pkg::CH_W-1:0] med0;
  logic [imf_pkg::CH_W-1:0] med1;
  logic [imf_pkg::CH_W-1:0] med2;
  logic                     end_of_frame;

  modport source (output valid, output med0, output med1, output med2,
                  output end_of_frame, input ready);
  modport sink (input valid, input med0, input med1, input med2,
                input end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: hdl/imf_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (old data on a
// read of the address being written).
// ---------------------------------------------------------------------------
`default_nettype none

module imf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/imf_ctrl.sv
// ---------------------------------------------------------------------------
// Median filter control
// Configuration registers, input and output raster positions, result
// release decision and line store addressing for each window tap.
// ---------------------------------------------------------------------------
`default_nettype none

module imf_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [imf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [imf_pkg::CFG_DW-1:0]      cfg_data_i,
  input  logic                            acc_i,
  input  logic                            op_i,
  output imf_pkg::wr_req_t                wr_o,
  output logic                            emit_o,
  output imf_pkg::rd_req_t                rd_o
);
  import imf_pkg::*;

  logic [WIDTH_W-1:0]  cfg_width_q;
  logic [HEIGHT_W-1:0] cfg_height_q;
  logic [CHN_W-1:0]    cfg_chans_q;

  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [DIFF_W-1:0] diff_q, diff_d;
  rd_req_t           rd_q, rd_d;

  logic [WEFF_W-1:0]   w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [CHN_W-1:0]    nch_eff;
  logic [DIFF_W-1:0]   lag;
  logic                pixel, restart, emit;
  logic [WEFF_W-1:0]   col_inc;
  logic [COL_W-1:0]    oc_cur;
  logic [ROW_W-1:0]    or_cur;
  logic signed [POS_W-1:0] pos;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(cfg_width_q);
    end
    h_eff   = (cfg_height_q == '0) ? HEIGHT_W'(1) : cfg_height_q;
    nch_eff = (cfg_chans_q == '0) ? CHN_W'(1) : cfg_chans_q;
    if (32'(nch_eff) > 32'(MAX_CHANNELS)) begin
      nch_eff = CHN_W'(MAX_CHANNELS);
    end
    lag = DIFF_W'(w_eff) * DIFF_W'(WIN_ROWS - 1) + DIFF_W'(WIN_COLS - 1);

    pixel   = acc_i && (op_i == OP_PIXEL);
    restart = pixel && (in_row_q >= h_eff);
    col_inc = '0;

    in_col_d  = restart ? '0 : in_col_q;
    in_row_d  = restart ? '0 : in_row_q;
    out_col_d = restart ? '0 : out_col_q;
    out_row_d = restart ? '0 : out_row_q;
    diff_d    = restart ? '0 : diff_q;

    wr_o.en   = pixel;
    wr_o.slot = in_row_d[RING_B-1:0];
    wr_o.col  = in_col_d;

    if (pixel) begin
      col_inc = {1'b0, in_col_d} + WEFF_W'(1);
      if (col_inc >= w_eff) begin
        in_col_d = '0;
        in_row_d = in_row_d + ROW_W'(1);
      end else begin
        in_col_d = col_inc[COL_W-1:0];
      end
      diff_d = diff_d + DIFF_W'(1);
    end

    oc_cur = out_col_d;
    or_cur = out_row_d;
    emit = acc_i && (out_row_d < h_eff) &&
           ((in_row_d >= h_eff) || (diff_d >= lag + DIFF_W'(1)));

    rd_d = '0;
    rd_d.side.valid = emit;
    rd_d.side.nch   = nch_eff;
    rd_d.side.eof   = (or_cur == h_eff - HEIGHT_W'(1)) &&
                      ({1'b0, oc_cur} == w_eff - WEFF_W'(1));
    for (int j = 0; j < WIN_ROWS; j++) begin
      pos = fold_pos(signed'(POS_W'(or_cur)) + POS_W'(j - WIN_ROWS / 2),
                     POS_W'(WIN_ROWS), signed'(POS_W'(h_eff)));
      rd_d.slot[j] = pos[RING_B-1:0];
    end
    for (int i = 0; i < WIN_COLS; i++) begin
      pos = fold_pos(signed'(POS_W'(oc_cur)) + POS_W'(i - WIN_COLS / 2),
                     POS_W'(WIN_COLS), signed'(POS_W'(w_eff)));
      rd_d.col[i] = pos[COL_W-1:0];
    end

    if (emit) begin
      col_inc = {1'b0, out_col_d} + WEFF_W'(1);
      if (col_inc >= w_eff) begin
        out_col_d = '0;
        out_row_d = out_row_d + ROW_W'(1);
      end else begin
        out_col_d = col_inc[COL_W-1:0];
      end
      diff_d = diff_d - DIFF_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_W'(1024);
      cfg_height_q <= HEIGHT_W'(1);
      cfg_chans_q  <= CHN_W'(3);
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      diff_q       <= '0;
      rd_q         <= '0;
    end else begin
      rd_q <= rd_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH: begin
            cfg_width_q <= cfg_data_i[WIDTH_W-1:0];
          end
          CFG_HEIGHT: begin
            cfg_height_q <= cfg_data_i[HEIGHT_W-1:0];
          end
          CFG_CHANNELS: begin
            cfg_chans_q <= cfg_data_i[CHN_W-1:0];
          end
          default: begin
          end
        endcase
        if (cfg_idx_i inside {CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS}) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          diff_q    <= '0;
        end
      end else if (acc_i) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
        diff_q    <= diff_d;
      end
    end
  end

  assign emit_o = emit;
  assign rd_o   = rd_q;

endmodule

`default_nettype wire

FILE: hdl/imf_lane.sv
// ---------------------------------------------------------------------------
// Median filter lane
// Pipelined odd-even transposition sort of one channel's window; the
// middle element of the last stage is the median.
// ---------------------------------------------------------------------------
`default_nettype none

module imf_lane (
  input  logic                     clk_i,
  input  logic [imf_pkg::CH_W-1:0] win_i [imf_pkg::WIN_N],
  output logic [imf_pkg::CH_W-1:0] med_o
);
  import imf_pkg::*;

  logic [CH_W-1:0] stg_q [WIN_N+1][WIN_N];
  logic [CH_W-1:0] stg_d [WIN_N+1][WIN_N];

  always_comb begin
    stg_d[0] = win_i;
    for (int s = 1; s <= WIN_N; s++) begin
      stg_d[s] = stg_q[s-1];
      for (int k = 0; k < WIN_N - 1; k++) begin
        if (((k ^ (s - 1)) & 1) == 0) begin
          if (stg_q[s-1][k] > stg_q[s-1][k+1]) begin
            stg_d[s][k]   = stg_q[s-1][k+1];
            stg_d[s][k+1] = stg_q[s-1][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign med_o = stg_q[WIN_N][WIN_N/2];

endmodule

`default_nettype wire

FILE: hdl/imf_merge.sv
// ---------------------------------------------------------------------------
// Median filter merge
// Joins the lane medians into one result, masks unused channels, and
// buffers results in an output queue sized for every result in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module imf_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     reserve_i,
  input  imf_pkg::side_t           side_i,
  input  logic [imf_pkg::CH_W-1:0] med_i [imf_pkg::NUM_CH],
  output logic                     credit_ok_o,
  output imf_pkg::mrg_status_t     status_o,
  imf_res_if.source                out_ch
);
  import imf_pkg::*;

  localparam int ENT_W = PIX_W + 1;

  logic [ENT_W-1:0]   fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [PEND_W-1:0]  cnt_q, pend_q;
  logic [ENT_W-1:0]   ent;
  logic               pop;

  always_comb begin
    ent = '0;
    ent[PIX_W] = side_i.eof;
    for (int c = 0; c < NUM_CH; c++) begin
      if (CHN_W'(c) < side_i.nch) begin
        ent[c*CH_W +: CH_W] = med_i[c];
      end
    end
  end

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i) begin
    if (side_i.valid) begin
      fifo_q[wptr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      if (side_i.valid) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      cnt_q  <= cnt_q + PEND_W'(side_i.valid) - PEND_W'(pop);
      pend_q <= pend_q + PEND_W'(reserve_i) - PEND_W'(pop);
    end
  end

  assign credit_ok_o         = pend_q < PEND_W'(FIFO_DEPTH);
  assign status_o.pend       = pend_q;
  assign status_o.count      = cnt_q;
  assign out_ch.valid        = cnt_q != '0;
  assign out_ch.med0         = fifo_q[rptr_q][0*CH_W +: CH_W];
  assign out_ch.med1         = fifo_q[rptr_q][1*CH_W +: CH_W];
  assign out_ch.med2         = fifo_q[rptr_q][2*CH_W +: CH_W];
  assign out_ch.end_of_frame = fifo_q[rptr_q][PIX_W];

endmodule

`default_nettype wire

FILE: hdl/image_median_filter.sv
// ---------------------------------------------------------------------------
// Image median filter
// Streaming per-channel median over a raster window with ring line stores,
// one sorting lane per channel and a merging output queue.
// ---------------------------------------------------------------------------
//  Port        Dir  Moves
//  in_ch       in   pixel or drain transaction (op, chan0..chan2)
//  out_ch      out  result transaction (med0..med2, end_of_frame)
//  cfg_*       in   register write (width, height, channel count)
//
//  One transaction is taken per clock while the output queue has room.
//  A result passes through the control read register, the line store read,
//  the sorting network stages in each lane and then the output queue.
//  Output stalls are absorbed by the queue; input ready drops only when
//  every queue entry is claimed by a result in flight.
//  Reset clears positions and control; the line store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module image_median_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [imf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [imf_pkg::CFG_DW-1:0]    cfg_data_i,
  imf_pix_if.sink                       in_ch,
  imf_res_if.source                     out_ch
);
  import imf_pkg::*;

  logic        in_acc, emit, credit_ok;
  wr_req_t     wr;
  rd_req_t     rd;
  mrg_status_t mst;

  logic [PIX_W-1:0] wdata;
  logic [PIX_W-1:0] rd_data [WIN_COLS][RING_ROWS];

  side_t                           side2_q;
  logic [WIN_ROWS-1:0][RING_B-1:0] slot2_q;
  side_t                           side_q [WIN_N+1];

  logic [CH_W-1:0] win [NUM_CH][WIN_N];
  logic [CH_W-1:0] med [NUM_CH];

  assign in_ch.ready = credit_ok;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wdata       = {in_ch.chan2, in_ch.chan1, in_ch.chan0};

  imf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (in_acc),
    .op_i       (in_ch.op),
    .wr_o       (wr),
    .emit_o     (emit),
    .rd_o       (rd)
  );

  for (genvar i = 0; i < WIN_COLS; i++) begin : g_col
    for (genvar k = 0; k < RING_ROWS; k++) begin : g_row
      imf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (wr.en && (wr.slot == RING_B'(k))),
        .waddr_i (wr.col),
        .wdata_i (wdata),
        .raddr_i (rd.col[i]),
        .rdata_o (rd_data[i][k])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side2_q <= '0;
      for (int s = 0; s <= WIN_N; s++) begin
        side_q[s] <= '0;
      end
    end else begin
      side2_q   <= rd.side;
      side_q[0] <= side2_q;
      for (int s = 1; s <= WIN_N; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot2_q <= rd.slot;
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int j = 0; j < WIN_ROWS; j++) begin
        for (int i = 0; i < WIN_COLS; i++) begin
          win[c][j*WIN_COLS+i] = rd_data[i][slot2_q[j]][c*CH_W +: CH_W];
        end
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    imf_lane u_lane (
      .clk_i (clk_i),
      .win_i (win[c]),
      .med_o (med[c])
    );
  end

  imf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (in_acc && emit),
    .side_i      (side_q[WIN_N]),
    .med_i       (med),
    .credit_ok_o (credit_ok),
    .status_o    (mst),
    .out_ch      (out_ch)
  );

  `IMF_ASSERT_IMPL(a_out_needs_pend, clk_i, rst_ni, out_ch.valid, mst.pend != '0, "result without claim")
  `IMF_ASSERT_IMPL(a_queue_le_pend, clk_i, rst_ni, 1'b1, mst.count <= mst.pend, "queue above claims")
  `IMF_ASSERT_IMPL(a_drain_no_write, clk_i, rst_ni, in_acc && (in_ch.op == OP_DRAIN), !wr.en, "drain wrote store")
  `IMF_ASSERT_NEXT(a_release_tracked, clk_i, rst_ni, in_acc && emit && !(out_ch.valid && out_ch.ready), mst.pend != '0, "lost claim")

endmodule

`default_nettype wire
